FILE: hw/rtl/bia_pkg.sv
`timescale 1ns / 1ps
package bia_pkg;

	localparam int BITS_DEF = 1024;
	localparam int WORD_W   = 32;
	localparam int OFF_W    = 5;
	localparam int INDEX_W  = 10;
	localparam int AMT_W    = 6;
	localparam int OP_W     = 2;
	localparam int STATUS_W = 2;
	localparam int IN_W     = 24;
	localparam int OUT_W    = 16;

	typedef enum logic [OP_W-1:0] {
		OP_TAKE = 2'd0,
		OP_RUN  = 2'd1,
		OP_FREE = 2'd2
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK   = 2'd0,
		ST_FULL = 2'd1,
		ST_BAD  = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_PREP,
		S_FETCH,
		S_SCAN,
		S_DONE
	} state_t;

	typedef struct packed {
		logic              hit;
		logic [OFF_W-1:0]  off;
		logic [WORD_W-1:0] word;
	} unit_res_t;

endpackage

FILE: hw/rtl/bia_ram.sv
`timescale 1ns / 1ps
module bia_ram #(
	parameter int DEPTH = bia_pkg::BITS_DEF / bia_pkg::WORD_W,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic                      clk,
	input  logic                      we,
	input  logic [AW-1:0]             waddr,
	input  logic [bia_pkg::WORD_W-1:0] wdata,
	input  logic [AW-1:0]             raddr,
	output logic [bia_pkg::WORD_W-1:0] rdata
);

	logic [bia_pkg::WORD_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: hw/rtl/bia_word_unit.sv
`timescale 1ns / 1ps
module bia_word_unit (
	input  logic [bia_pkg::WORD_W-1:0] bits,
	input  logic [bia_pkg::WORD_W-1:0] base,
	input  logic [bia_pkg::WORD_W-1:0] allowed,
	output bia_pkg::unit_res_t         res
);

	logic [bia_pkg::WORD_W-1:0] fit;

	// a run fits at offset i when it is allowed there and every covered bit is free
	always_comb begin
		fit = '0;
		for (int i = 0; i < bia_pkg::WORD_W; i++) begin
			fit[i] = allowed[i] && ((bits & (base << i)) == '0);
		end
		res.hit = |fit;
		res.off = '0;
		for (int i = bia_pkg::WORD_W - 1; i >= 0; i--) begin
			if (fit[i]) begin
				res.off = bia_pkg::OFF_W'(i);
			end
		end
		res.word = bits | (base << res.off);
	end

endmodule

FILE: hw/rtl/bitmap_index_allocator_core.sv
`timescale 1ns / 1ps
// one request at a time; one bitmap word is read and evaluated per cycle
// take one: bitmap words are examined in turn, starting at the hint word
// take run: first builds the offset mask, then scans up to BITS/32 - 1 words
// release: a read-modify-write of a single word; a bad request goes straight to the result
// after reset the bitmap is cleared one word a cycle, all BITS/32 words, with s_tready low
module bitmap_index_allocator_core #(
	parameter int BITS = bia_pkg::BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [bia_pkg::IN_W-1:0]    s_tdata,   // op, amount, align, start_index
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [bia_pkg::OUT_W-1:0]   m_tdata    // index, status
);

	localparam int WORDS = BITS / bia_pkg::WORD_W;
	localparam int HW    = $clog2(BITS);
	localparam int WIDX  = $clog2(WORDS);
	localparam int W     = bia_pkg::WORD_W;

	bia_pkg::state_t  state_q, state_d;
	bia_pkg::op_t     op_q, in_op;
	bia_pkg::status_t res_status_q, out_status_q;

	logic [bia_pkg::AMT_W-1:0]   in_amount, in_align, lim_q, align_q, step_q;
	logic [bia_pkg::INDEX_W-1:0] in_start, res_index_q, out_index_q;
	logic [W-1:0]                in_base, base_q, allowed_q, lo_mask, allowed;
	logic [bia_pkg::OFF_W-1:0]   off0_q;
	logic [WIDX-1:0]             cur_w_q, clr_q, in_w, ram_waddr, ram_raddr;
	logic [WIDX:0]               cnt_q;
	logic [HW-1:0]               hint_q, hint_run, hit_pos;
	logic                        amt_bad, aln_bad, rel_bad, in_bad, accept, scan_last;
	logic                        ram_we, out_load;
	logic [W-1:0]                ram_wdata, ram_rdata;
	bia_pkg::unit_res_t          res;

	assign in_op     = bia_pkg::op_t'(s_tdata[1:0]);
	assign in_amount = s_tdata[7:2];
	assign in_align  = s_tdata[13:8];
	assign in_start  = s_tdata[23:14];

	assign amt_bad = (in_amount == '0) || (in_amount > 6'd32);
	assign aln_bad = (in_align == '0) || (in_align > 6'd32);
	assign rel_bad = amt_bad || ((in_start >> HW) != '0) ||
		((7'(in_start[bia_pkg::OFF_W-1:0]) + 7'(in_amount)) > 7'd32);
	assign in_base  = {W{1'b1}} >> (6'd32 - in_amount);
	assign hint_run = hint_q + HW'(31);

	always_comb begin
		unique case (in_op)
			bia_pkg::OP_TAKE: begin
				in_bad = 1'b0;
				in_w   = hint_q[HW-1:bia_pkg::OFF_W];
			end
			bia_pkg::OP_RUN: begin
				in_bad = amt_bad || aln_bad;
				in_w   = hint_run[HW-1:bia_pkg::OFF_W];
			end
			bia_pkg::OP_FREE: begin
				in_bad = rel_bad;
				in_w   = WIDX'(in_start[bia_pkg::INDEX_W-1:bia_pkg::OFF_W]);
			end
			default: begin
				in_bad = 1'b1;
				in_w   = '0;
			end
		endcase
	end

	assign accept   = s_tvalid && s_tready;
	assign out_load = (state_q == bia_pkg::S_DONE) && (!m_tvalid || m_tready);
	assign lo_mask  = (W'(1) << off0_q) - W'(1);
	assign hit_pos  = {cur_w_q, res.off};

	always_comb begin
		if (op_q == bia_pkg::OP_TAKE) begin
			scan_last = (cnt_q == (WIDX+1)'(WORDS));
			if (cnt_q == '0) begin
				allowed = ~lo_mask;
			end else if (scan_last) begin
				allowed = lo_mask;
			end else begin
				allowed = '1;
			end
		end else begin
			scan_last = (cnt_q == (WIDX+1)'(WORDS - 2));
			allowed   = allowed_q;
		end
	end

	bia_word_unit u_unit (
		.bits    (ram_rdata),
		.base    (base_q),
		.allowed (allowed),
		.res     (res)
	);

	bia_ram #(
		.DEPTH (WORDS),
		.AW    (WIDX)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			bia_pkg::S_CLEAR: begin
				if (clr_q == WIDX'(WORDS - 1)) state_d = bia_pkg::S_IDLE;
			end
			bia_pkg::S_IDLE: begin
				if (s_tvalid) begin
					if (in_bad) state_d = bia_pkg::S_DONE;
					else if (in_op == bia_pkg::OP_RUN) state_d = bia_pkg::S_PREP;
					else state_d = bia_pkg::S_FETCH;
				end
			end
			bia_pkg::S_PREP: begin
				if (step_q > lim_q) state_d = bia_pkg::S_FETCH;
			end
			bia_pkg::S_FETCH: state_d = bia_pkg::S_SCAN;
			bia_pkg::S_SCAN: begin
				if (op_q == bia_pkg::OP_FREE || res.hit || scan_last) state_d = bia_pkg::S_DONE;
			end
			bia_pkg::S_DONE: begin
				if (out_load) state_d = bia_pkg::S_IDLE;
			end
			default: state_d = bia_pkg::S_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		s_tready  = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = cur_w_q;
		ram_wdata = '0;
		ram_raddr = cur_w_q;
		unique case (state_q)
			bia_pkg::S_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
			end
			bia_pkg::S_IDLE: s_tready = 1'b1;
			bia_pkg::S_SCAN: begin
				ram_raddr = cur_w_q + WIDX'(1);
				if (op_q == bia_pkg::OP_FREE) begin
					ram_we    = 1'b1;
					ram_wdata = ram_rdata & ~base_q;
				end else if (res.hit) begin
					ram_we    = 1'b1;
					ram_wdata = res.word;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= bia_pkg::S_CLEAR;
			clr_q    <= '0;
			hint_q   <= '0;
			m_tvalid <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == bia_pkg::S_CLEAR) clr_q <= clr_q + WIDX'(1);
			if (state_q == bia_pkg::S_SCAN && op_q != bia_pkg::OP_FREE && res.hit) begin
				if (op_q == bia_pkg::OP_TAKE) hint_q <= hit_pos + HW'(1);
				else hint_q <= {cur_w_q, bia_pkg::OFF_W'(0)};
			end
			if (out_load) m_tvalid <= 1'b1;
			else if (m_tready) m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q      <= in_op;
			base_q    <= (in_op == bia_pkg::OP_TAKE) ? W'(1) :
				(in_op == bia_pkg::OP_FREE) ? (in_base << in_start[bia_pkg::OFF_W-1:0]) : in_base;
			lim_q     <= 6'd32 - in_amount;
			align_q   <= in_align;
			step_q    <= '0;
			allowed_q <= '0;
			off0_q    <= hint_q[bia_pkg::OFF_W-1:0];
			cur_w_q   <= in_w;
			cnt_q     <= '0;
			if (in_bad) begin
				res_index_q  <= '0;
				res_status_q <= bia_pkg::ST_BAD;
			end else begin
				res_index_q  <= in_start;
				res_status_q <= bia_pkg::ST_OK;
			end
		end
		if (state_q == bia_pkg::S_PREP && step_q <= lim_q) begin
			allowed_q[step_q[bia_pkg::OFF_W-1:0]] <= 1'b1;
			step_q <= step_q + align_q;
		end
		if (state_q == bia_pkg::S_SCAN) begin
			cur_w_q <= cur_w_q + WIDX'(1);
			cnt_q   <= cnt_q + (WIDX+1)'(1);
			if (op_q != bia_pkg::OP_FREE) begin
				if (res.hit) begin
					res_index_q  <= bia_pkg::INDEX_W'(hit_pos);
					res_status_q <= bia_pkg::ST_OK;
				end else begin
					res_index_q  <= '0;
					res_status_q <= bia_pkg::ST_FULL;
				end
			end
		end
		if (out_load) begin
			out_index_q  <= res_index_q;
			out_status_q <= res_status_q;
		end
	end

	assign m_tdata = {4'b0, out_status_q, out_index_q};

endmodule

FILE: bench/tb.sv
`timescale 1ns / 1ps
module tb;
	import bia_pkg::*;

	localparam int BITS        = 1024;
	localparam int WORDS       = BITS / 32;
	localparam int RANDOM_ITEMS = 780;
	localparam int QUIET_LIMIT = 3000;
	localparam int DRAIN_CYCLES = 80;
	localparam logic [OP_W-1:0] OP_UNKNOWN = 2'd3;

	// input transfer fields, lowest bits last
	typedef struct packed {
		logic [INDEX_W-1:0] start_index;
		logic [AMT_W-1:0]   align;
		logic [AMT_W-1:0]   amount;
		logic [OP_W-1:0]    op;
	} alloc_req_t;

	// result transfer fields, lowest bits last
	typedef struct packed {
		logic [OUT_W-INDEX_W-STATUS_W-1:0] pad;
		status_t                           status;
		logic [INDEX_W-1:0]                index;
	} grant_t;

	typedef struct packed {
		logic [OP_W-1:0]    op;
		logic [AMT_W-1:0]   amount;
		logic [AMT_W-1:0]   align;
		logic [INDEX_W-1:0] start_index;
		logic               typed;
		logic [INDEX_W-1:0] index;
		status_t            status;
	} directed_row_t;

	localparam int N_DIRECTED = 24;
	localparam directed_row_t DIRECTED [N_DIRECTED] = '{
		'{OP_TAKE,    6'd0,  6'd0,  10'd0,    1'b1, 10'd0,    ST_OK},
		'{OP_TAKE,    6'd63, 6'd63, 10'd1023, 1'b1, 10'd1,    ST_OK},
		'{OP_UNKNOWN, 6'd63, 6'd63, 10'd1023, 1'b1, 10'd0,    ST_BAD},
		'{OP_RUN,     6'd0,  6'd1,  10'd0,    1'b1, 10'd0,    ST_BAD},
		'{OP_RUN,     6'd33, 6'd1,  10'd0,    1'b1, 10'd0,    ST_BAD},
		'{OP_RUN,     6'd4,  6'd0,  10'd0,    1'b1, 10'd0,    ST_BAD},
		'{OP_RUN,     6'd4,  6'd33, 10'd0,    1'b1, 10'd0,    ST_BAD},
		'{OP_RUN,     6'd63, 6'd63, 10'd1023, 1'b1, 10'd0,    ST_BAD},
		'{OP_FREE,    6'd0,  6'd1,  10'd0,    1'b1, 10'd0,    ST_BAD},
		'{OP_FREE,    6'd33, 6'd1,  10'd0,    1'b1, 10'd0,    ST_BAD},
		'{OP_FREE,    6'd4,  6'd1,  10'd30,   1'b1, 10'd0,    ST_BAD},
		'{OP_FREE,    6'd32, 6'd1,  10'd1023, 1'b1, 10'd0,    ST_BAD},
		'{OP_RUN,     6'd32, 6'd1,  10'd0,    1'b1, 10'd32,   ST_OK},
		'{OP_RUN,     6'd1,  6'd32, 10'd0,    1'b1, 10'd64,   ST_OK},
		'{OP_RUN,     6'd32, 6'd32, 10'd0,    1'b1, 10'd96,   ST_OK},
		'{OP_FREE,    6'd32, 6'd1,  10'd32,   1'b1, 10'd32,   ST_OK},
		'{OP_FREE,    6'd1,  6'd1,  10'd1023, 1'b1, 10'd1023, ST_OK},
		'{OP_FREE,    6'd31, 6'd1,  10'd1,    1'b1, 10'd1,    ST_OK},
		'{OP_RUN,     6'd5,  6'd3,  10'd0,    1'b0, 10'd0,    ST_OK},
		'{OP_TAKE,    6'd1,  6'd1,  10'd512,  1'b0, 10'd0,    ST_OK},
		'{OP_TAKE,    6'd2,  6'd2,  10'd513,  1'b0, 10'd0,    ST_OK},
		'{OP_RUN,     6'd17, 6'd7,  10'd0,    1'b0, 10'd0,    ST_OK},
		'{OP_FREE,    6'd32, 6'd1,  10'd0,    1'b1, 10'd0,    ST_OK},
		'{OP_TAKE,    6'd0,  6'd0,  10'd0,    1'b0, 10'd0,    ST_OK}
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [IN_W-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_W-1:0] m_tdata;

	logic [31:0] taken_map [WORDS];
	logic [INDEX_W-1:0] hint_bit;
	grant_t expected_grants [$];
	int fail_count = 0;
	int quiet_cycles = 0;
	bit calm = 1'b0;

	bitmap_index_allocator_core #(.BITS(BITS)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	always #5 clk = ~clk;

	function automatic grant_t predict_grant(alloc_req_t r);
		grant_t g;
		logic [INDEX_W-1:0] pos;
		logic [INDEX_W-1:0] rounded;
		logic [4:0] w;
		logic [4:0] off;
		logic [31:0] base;
		logic [31:0] m;
		int amt;
		int step;
		g = '0;
		g.status = ST_BAD;
		amt = int'(r.amount);
		step = int'(r.align);
		case (r.op)
			OP_TAKE: begin
				g.status = ST_FULL;
				pos = hint_bit;
				for (int n = 0; n < BITS; n++) begin
					if (!taken_map[pos[9:5]][pos[4:0]]) begin
						taken_map[pos[9:5]][pos[4:0]] = 1'b1;
						hint_bit = pos + 10'd1;
						g.index = pos;
						g.status = ST_OK;
						return g;
					end
					pos = pos + 10'd1;
				end
			end
			OP_RUN: begin
				if (amt == 0 || amt > 32 || step == 0 || step > 32)
					return g;
				g.status = ST_FULL;
				base = 32'hFFFF_FFFF >> (32 - amt);
				rounded = hint_bit + 10'd31;
				w = rounded[9:5];
				// the word just before the start word is never looked at
				for (int n = 0; n < WORDS - 1; n++) begin
					if (taken_map[w] != 32'hFFFF_FFFF) begin
						for (int i = 0; i <= 32 - amt; i += step) begin
							m = base << i;
							if ((taken_map[w] & m) == '0) begin
								taken_map[w] = taken_map[w] | m;
								hint_bit = {w, 5'd0};
								g.index = {w, 5'd0} + 10'(i);
								g.status = ST_OK;
								return g;
							end
						end
					end
					w = w + 5'd1;
				end
			end
			OP_FREE: begin
				off = r.start_index[4:0];
				if (amt == 0 || amt > 32 || int'(off) + amt > 32)
					return g;
				m = (32'hFFFF_FFFF >> (32 - amt)) << off;
				taken_map[r.start_index[9:5]] = taken_map[r.start_index[9:5]] & ~m;
				g.index = r.start_index;
				g.status = ST_OK;
			end
			default: ;
		endcase
		return g;
	endfunction

	function automatic bit map_full();
		for (int k = 0; k < WORDS; k++)
			if (taken_map[k] != 32'hFFFF_FFFF)
				return 1'b0;
		return 1'b1;
	endfunction

	function automatic alloc_req_t make_req(logic [OP_W-1:0] op, int amount, int align,
			int start_index);
		alloc_req_t r;
		r.op = op;
		r.amount = AMT_W'(amount);
		r.align = AMT_W'(align);
		r.start_index = INDEX_W'(start_index);
		return r;
	endfunction

	function automatic alloc_req_t random_req();
		alloc_req_t r;
		int pick;
		r = make_req(OP_TAKE, $urandom_range(0, 63), $urandom_range(0, 63),
			$urandom_range(0, BITS - 1));
		pick = $urandom_range(0, 99);
		if (pick < 35) begin
			r.op = OP_TAKE;
		end else if (pick < 62) begin
			r.op = OP_RUN;
			if ($urandom_range(0, 19) != 0) begin
				r.amount = AMT_W'(($urandom_range(0, 3) == 0) ?
					$urandom_range(1, 32) : $urandom_range(1, 8));
				r.align = AMT_W'(($urandom_range(0, 3) == 0) ?
					$urandom_range(1, 32) : $urandom_range(1, 4));
			end
		end else if (pick < 95) begin
			r.op = OP_FREE;
			if ($urandom_range(0, 9) != 0)
				r.amount = AMT_W'($urandom_range(1, 32 - int'(r.start_index[4:0])));
		end else begin
			r.op = OP_UNKNOWN;
		end
		return r;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("%0t mismatch on %s: got %0d want %0d", $realtime, what, got, want);
		fail_count++;
	endtask

	// called and returns at a falling edge
	task automatic send_req(alloc_req_t r, bit typed = 1'b0, grant_t want = '0);
		grant_t g;
		while (!calm && $urandom_range(0, 99) < 13) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= r;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		g = predict_grant(r);
		expected_grants.push_back(typed ? want : g);
		@(negedge clk);
	endtask

	// empty the map, fill it, then hit the no-room and skipped-word cases
	task automatic fill_and_starve();
		logic [INDEX_W-1:0] rounded;
		logic [4:0] gap_word;
		for (int k = 0; k < WORDS; k++)
			send_req(make_req(OP_FREE, 32, $urandom_range(0, 63), k * 32));
		repeat (WORDS)
			send_req(make_req(OP_RUN, 32, 32, $urandom_range(0, BITS - 1)));
		while (!map_full())
			send_req(make_req(OP_TAKE, $urandom_range(0, 63), $urandom_range(0, 63),
				$urandom_range(0, BITS - 1)));
		send_req(make_req(OP_TAKE, 0, 0, 0));
		send_req(make_req(OP_RUN, 1, 1, 0));
		rounded = hint_bit + 10'd31;
		gap_word = rounded[9:5] - 5'd1;
		send_req(make_req(OP_FREE, 32, 1, int'({gap_word, 5'd0})));
		send_req(make_req(OP_RUN, $urandom_range(1, 32), $urandom_range(1, 32), 0));
		send_req(make_req(OP_TAKE, 0, 0, 0));
	endtask

	always @(negedge clk)
		m_tready <= calm || ($urandom_range(0, 99) >= 13);

	always @(posedge clk) begin
		grant_t got;
		grant_t want;
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (m_tvalid && m_tready) begin
				got = m_tdata;
				if (expected_grants.size() == 0) begin
					report_mismatch("unexpected result transfer", int'(got.index), 0);
				end else begin
					want = expected_grants.pop_front();
					if (got.index !== want.index)
						report_mismatch("index", int'(got.index), int'(want.index));
					if (got.status !== want.status)
						report_mismatch("status", int'(got.status), int'(want.status));
					if (got.pad !== want.pad)
						report_mismatch("pad bits", int'(got.pad), int'(want.pad));
				end
			end
		end
	end

	always @(posedge clk) begin
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("tb failed");
			$finish;
		end
	end

	initial begin
		grant_t want;
		for (int k = 0; k < WORDS; k++)
			taken_map[k] = '0;
		hint_bit = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (DIRECTED[k]) begin
			want = '0;
			want.index = DIRECTED[k].index;
			want.status = DIRECTED[k].status;
			send_req(make_req(DIRECTED[k].op, int'(DIRECTED[k].amount),
				int'(DIRECTED[k].align), int'(DIRECTED[k].start_index)),
				DIRECTED[k].typed, want);
		end

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			calm <= (n >= 300 && n < 450);
			if (n == 150 || n == 550)
				fill_and_starve();
			send_req(random_req());
		end
		s_tvalid <= 1'b0;

		while (expected_grants.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end

endmodule
